// ----- rtl/akdl_pkg.sv -----
// ----------------------------------------------------------------------------
// akdl_pkg
// Shared types and constants for the ladder keypad debounce and long-press
// block: event kinds, key identifiers, register indexes and reset values.
// ----------------------------------------------------------------------------
package akdl_pkg;

  // Field widths
  localparam int unsigned TimeW = 32;
  localparam int unsigned MvW   = 12;
  localparam int unsigned MsW   = 16;
  localparam int unsigned KeyW  = 2;
  localparam int unsigned IdxW  = 3;

  // Minimum hold for a short press, strictly exceeded
  localparam logic [TimeW-1:0] SHORT_MIN_MS = 32'd10;

  // Register reset values
  localparam logic [MvW-1:0] WIN_MIN_RST  = 12'd4095;
  localparam logic [MvW-1:0] WIN_MAX_RST  = 12'd0;
  localparam logic [MsW-1:0] DEBOUNCE_RST = 16'd25;
  localparam logic [MsW-1:0] LONG_RST     = 16'd800;

  // Key identifiers
  localparam logic [KeyW-1:0] KEY_NONE = 2'd0;
  localparam logic [KeyW-1:0] KEY_ONE  = 2'd1;
  localparam logic [KeyW-1:0] KEY_TWO  = 2'd2;
  localparam logic [KeyW-1:0] KEY_BOTH = 2'd3;

  // Event kinds carried on the result channel
  typedef enum logic [1:0] {
    EV_DOWN       = 2'd0,
    EV_SHORT      = 2'd1,
    EV_LONG_START = 2'd2,
    EV_LONG_END   = 2'd3
  } event_kind_e;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_BOTH_MIN = 3'd0,
    REG_BOTH_MAX = 3'd1,
    REG_KEY2_MIN = 3'd2,
    REG_KEY2_MAX = 3'd3,
    REG_KEY1_MIN = 3'd4,
    REG_KEY1_MAX = 3'd5,
    REG_DEBOUNCE = 3'd6,
    REG_LONG     = 3'd7
  } cfg_reg_e;

endpackage

// ----- rtl/adc_ladder_key_debounce_longpress.sv -----
// ----------------------------------------------------------------------------
// adc_ladder_key_debounce_longpress
// Classifies ladder ADC samples into keys, debounces the press state and
// reports down, short press, long-press start and long-press end events.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transaction contents
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | one scan sample: time, raw code, millivolts, error flag
//  m_axis   | out | zero or one event per sample: kind, key, echoes
//  cfg      | in  | register index and write data, always ready
//
//  One sample is accepted every cycle while the output does not stall; the
//  sample waits in the input register, then the decision logic of compares
//  and two 32-bit time differences writes its event into the result register.
//  Only m_axis_tready stalls the block: a held result also holds the sample
//  waiting in the input register. Reset clears the key state and loads the
//  register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adc_ladder_key_debounce_longpress
  import akdl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Sample stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,  // now_ms[31:0], raw_code[43:32], sample_mv[55:44]
  input  logic [0:0]       s_axis_tuser,  // adc_error[0]
  // Event stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // key_id[1:0], raw_echo[13:2], mv_echo[25:14], zero
  output logic [1:0]       m_axis_tuser,  // event_kind[1:0]
  // Configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [MsW-1:0]   cfg_data_i
);

  // Configuration registers
  logic [MvW-1:0] both_min_q, both_max_q, key2_min_q, key2_max_q;
  logic [MvW-1:0] key1_min_q, key1_max_q;
  logic [MsW-1:0] debounce_q, long_q;

  // Input register
  logic             in_valid_q, in_valid_d;
  logic [TimeW-1:0] in_now_q;
  logic [MvW-1:0]   in_raw_q, in_mv_q;
  logic             in_err_q;

  // Key state
  logic             pressed_q, pressed_d;
  logic             prev_q, prev_d;
  logic             reported_q, reported_d;
  logic [KeyW-1:0]  held_q, held_d;
  logic [TimeW-1:0] press_t_q, press_t_d;
  logic [TimeW-1:0] change_t_q, change_t_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  event_kind_e      out_kind_q;
  logic [KeyW-1:0]  out_key_q;
  logic [MvW-1:0]   out_raw_q, out_mv_q;

  logic             s_accept, advance, out_free;
  logic [KeyW-1:0]  key_c, ev_key;
  logic             reading, settled, emit;
  logic [TimeW-1:0] since_change, since_press;
  event_kind_e      kind;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      both_min_q <= WIN_MIN_RST;
      both_max_q <= WIN_MAX_RST;
      key2_min_q <= WIN_MIN_RST;
      key2_max_q <= WIN_MAX_RST;
      key1_min_q <= WIN_MIN_RST;
      key1_max_q <= WIN_MAX_RST;
      debounce_q <= DEBOUNCE_RST;
      long_q     <= LONG_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BOTH_MIN: both_min_q <= cfg_data_i[MvW-1:0];
        REG_BOTH_MAX: both_max_q <= cfg_data_i[MvW-1:0];
        REG_KEY2_MIN: key2_min_q <= cfg_data_i[MvW-1:0];
        REG_KEY2_MAX: key2_max_q <= cfg_data_i[MvW-1:0];
        REG_KEY1_MIN: key1_min_q <= cfg_data_i[MvW-1:0];
        REG_KEY1_MAX: key1_max_q <= cfg_data_i[MvW-1:0];
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        REG_LONG:     long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the sample
  assign in_valid_d = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_now_q <= s_axis_tdata[31:0];
      in_raw_q <= s_axis_tdata[43:32];
      in_mv_q  <= s_axis_tdata[55:44];
      in_err_q <= s_axis_tuser[0];
    end
  end

  // Classify through the windows, both keys first
  always_comb begin
    if (in_mv_q >= both_min_q && in_mv_q <= both_max_q) begin
      key_c = KEY_BOTH;
    end else if (in_mv_q >= key2_min_q && in_mv_q <= key2_max_q) begin
      key_c = KEY_TWO;
    end else if (in_mv_q >= key1_min_q && in_mv_q <= key1_max_q) begin
      key_c = KEY_ONE;
    end else begin
      key_c = KEY_NONE;
    end
  end

  assign reading      = (key_c != KEY_NONE);
  assign since_change = in_now_q - change_t_q;
  assign since_press  = in_now_q - press_t_q;
  // A reading that just changed has zero stable time and cannot settle
  assign settled      = (reading == prev_q) && (since_change > {16'd0, debounce_q})
                        && (reading != pressed_q);

  // Decide the event and the next key state
  always_comb begin
    pressed_d  = pressed_q;
    prev_d     = prev_q;
    reported_d = reported_q;
    held_d     = held_q;
    press_t_d  = press_t_q;
    change_t_d = change_t_q;
    emit       = 1'b0;
    kind       = EV_DOWN;
    ev_key     = held_q;
    if (advance && !in_err_q) begin
      prev_d = reading;
      if (reading != prev_q) begin
        change_t_d = in_now_q;
      end
      if (settled) begin
        pressed_d = reading;
        if (reading) begin
          held_d     = key_c;
          ev_key     = key_c;
          press_t_d  = in_now_q;
          reported_d = 1'b0;
          emit       = 1'b1;
          kind       = EV_DOWN;
        end else if (reported_q) begin
          emit   = 1'b1;
          kind   = EV_LONG_END;
          held_d = KEY_NONE;
        end else if (since_press > SHORT_MIN_MS) begin
          emit   = 1'b1;
          kind   = EV_SHORT;
          held_d = KEY_NONE;
        end
      end else if (pressed_q && since_press > {16'd0, long_q} && !reported_q) begin
        // Report long press once; later held samples stay silent
        emit       = 1'b1;
        kind       = EV_LONG_START;
        reported_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= 1'b0;
      prev_q     <= 1'b0;
      reported_q <= 1'b0;
      held_q     <= KEY_NONE;
      press_t_q  <= '0;
      change_t_q <= '0;
    end else begin
      pressed_q  <= pressed_d;
      prev_q     <= prev_d;
      reported_q <= reported_d;
      held_q     <= held_d;
      press_t_q  <= press_t_d;
      change_t_q <= change_t_d;
    end
  end

  // Hold the result until taken
  assign out_valid_d = advance ? emit : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_kind_q <= kind;
      out_key_q  <= ev_key;
      out_raw_q  <= in_raw_q;
      out_mv_q   <= in_mv_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_mv_q, out_raw_q, out_key_q};
  assign m_axis_tuser  = out_kind_q;

  // A down event leaves the key pressed with a real key latched
  a_down_pressed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == EV_DOWN) |-> (pressed_q && held_q != KEY_NONE))
    else $error("down event without pressed state");

  // Long-press start is only reported while pressed, and marks it reported
  a_long_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == EV_LONG_START) |-> (pressed_q && reported_q))
    else $error("long-press start outside a press");

  // Release events drop the latched key
  a_release_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == EV_SHORT || out_kind_q == EV_LONG_END))
      |-> (!pressed_q && held_q == KEY_NONE))
    else $error("release event left key state behind");

  // Key state only moves when a sample goes through
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(pressed_q) && $stable(held_q) && $stable(change_t_q)))
    else $error("key state changed without a sample");

  // A stalled result stops the input stage from advancing
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("sample advanced over a held result");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ladder keypad debounce and long-press block.
// A directed table covers reset state, window extremes and priority, quick
// release, long press and timestamp wrap; random scan streams then run under
// eight register settings and four idling patterns. Every accepted sample is
// fed to an in-bench key-state tracker and its events are compared in order.
// ----------------------------------------------------------------------------
module tb_top
  import akdl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Scan sample and key event as seen on the streams
  typedef struct packed {
    logic [31:0] now;
    logic [11:0] raw;
    logic [11:0] mv;
    logic        err;
  } sample_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  key;
    logic [11:0] raw;
    logic [11:0] mv;
  } key_event_t;

  // One row of the directed table; t_* hold a hand-typed expectation
  typedef struct {
    bit          setup;
    logic [31:0] now;
    logic [11:0] raw;
    logic [11:0] mv;
    logic        err;
    bit          typed;
    bit          t_has;
    logic [1:0]  t_kind;
    logic [1:0]  t_key;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [55:0]      s_axis_tdata = '0;  // now_ms[31:0], raw_code[43:32], sample_mv[55:44]
  logic [0:0]       s_axis_tuser = '0;  // adc_error[0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [31:0]      m_axis_tdata;       // key_id[1:0], raw_echo[13:2], mv_echo[25:14], zero
  logic [1:0]       m_axis_tuser;       // event_kind[1:0]
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IdxW-1:0]  cfg_index_i = '0;
  logic [MsW-1:0]   cfg_data_i = '0;

  adc_ladder_key_debounce_longpress dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Key-state tracker
  // --------------------------------------------------------------------------
  logic [11:0] both_min, both_max, key2_min, key2_max, key1_min, key1_max;
  logic [15:0] debounce_ms, long_press_ms;
  bit          debounced, prev_reading, long_seen;
  logic [1:0]  held_key;
  logic [31:0] press_start, last_change;

  key_event_t  pending_events[$];
  int          mismatches = 0;
  int          idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  logic [15:0] cfg_plan [8];

  function automatic void reset_tracker();
    both_min = WIN_MIN_RST;  both_max = WIN_MAX_RST;
    key2_min = WIN_MIN_RST;  key2_max = WIN_MAX_RST;
    key1_min = WIN_MIN_RST;  key1_max = WIN_MAX_RST;
    debounce_ms = DEBOUNCE_RST;
    long_press_ms = LONG_RST;
    debounced = 1'b0;
    prev_reading = 1'b0;
    long_seen = 1'b0;
    held_key = KEY_NONE;
    press_start = '0;
    last_change = '0;
  endfunction

  function automatic void tracker_write(input cfg_reg_e idx, input logic [15:0] val);
    case (idx)
      REG_BOTH_MIN: both_min = val[11:0];
      REG_BOTH_MAX: both_max = val[11:0];
      REG_KEY2_MIN: key2_min = val[11:0];
      REG_KEY2_MAX: key2_max = val[11:0];
      REG_KEY1_MIN: key1_min = val[11:0];
      REG_KEY1_MAX: key1_max = val[11:0];
      REG_DEBOUNCE: debounce_ms = val;
      default:      long_press_ms = val;
    endcase
  endfunction

  // Windows are inclusive and tried in priority order: both, key two, key one
  function automatic logic [1:0] classify_mv(input logic [11:0] mv);
    if (mv >= both_min && mv <= both_max) return KEY_BOTH;
    if (mv >= key2_min && mv <= key2_max) return KEY_TWO;
    if (mv >= key1_min && mv <= key1_max) return KEY_ONE;
    return KEY_NONE;
  endfunction

  // Advance the key state by one sample; return 1 when it yields an event
  function automatic bit predict_key_event(input sample_t s, output key_event_t ev);
    logic [1:0]  key_now;
    logic [1:0]  ev_key;
    logic [1:0]  kind;
    logic [31:0] since_change;
    logic [31:0] since_press;
    bit          reading;
    bit          emit;
    ev = '0;
    emit = 1'b0;
    kind = EV_DOWN;
    if (s.err) return 1'b0;
    key_now = classify_mv(s.mv);
    reading = (key_now != KEY_NONE);
    ev_key = held_key;
    if (reading != prev_reading) last_change = s.now;
    since_change = s.now - last_change;
    // Debounced state follows the reading once it has been stable long enough
    if (since_change > {16'd0, debounce_ms} && reading != debounced) begin
      debounced = reading;
      if (reading) begin
        held_key = key_now;
        ev_key = key_now;
        press_start = s.now;
        long_seen = 1'b0;
        kind = EV_DOWN;
        emit = 1'b1;
      end else begin
        since_press = s.now - press_start;
        if (long_seen) begin
          kind = EV_LONG_END;
          emit = 1'b1;
        end else if (since_press > SHORT_MIN_MS) begin
          kind = EV_SHORT;
          emit = 1'b1;
        end
      end
    end
    // Long press fires once per press; later held samples stay quiet
    since_press = s.now - press_start;
    if (debounced && since_press > {16'd0, long_press_ms}) begin
      ev_key = held_key;
      if (!long_seen) begin
        kind = EV_LONG_START;
        emit = 1'b1;
        long_seen = 1'b1;
      end
    end
    // A reported release forgets the key; a quick release keeps it
    if (!debounced && emit) held_key = KEY_NONE;
    prev_reading = reading;
    ev = '{kind: kind, key: ev_key, raw: s.raw, mv: s.mv};
    return emit;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  function automatic bit sender_idles();
    case (idle_mode)
      1:       return $urandom_range(0, 99) < 47;
      3:       return $urandom_range(0, 99) < 33;
      default: return 1'b0;
    endcase
  endfunction

  // Present one sample and hold it until accepted, then predict its event
  task automatic send_sample(input sample_t s, output bit has, output key_event_t ev);
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s.mv, s.raw, s.now};
    s_axis_tuser <= s.err;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has = predict_key_event(s, ev);
  endtask

  // Drop the sample stream and wait for every outstanding event plus latency
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_plan(input int bmin, input int bmax, input int k2min, input int k2max,
                          input int k1min, input int k1max, input int deb, input int lng);
    cfg_plan[REG_BOTH_MIN] = bmin[15:0];
    cfg_plan[REG_BOTH_MAX] = bmax[15:0];
    cfg_plan[REG_KEY2_MIN] = k2min[15:0];
    cfg_plan[REG_KEY2_MAX] = k2max[15:0];
    cfg_plan[REG_KEY1_MIN] = k1min[15:0];
    cfg_plan[REG_KEY1_MAX] = k1max[15:0];
    cfg_plan[REG_DEBOUNCE] = deb[15:0];
    cfg_plan[REG_LONG]     = lng[15:0];
  endtask

  // Write every register of the plan back to back, one transaction each
  task automatic write_cfg_plan();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= cfg_plan[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker_write(cfg_reg_e'(i), cfg_plan[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random window: lo..lo+span, clipped to the 12-bit range
  function automatic int rand_hi(input int lo, input int span);
    int hi;
    hi = lo + $urandom_range(0, span);
    return (hi > 4095) ? 4095 : hi;
  endfunction

  // Millivolt value aimed at one key; falls back to noise when the window is empty
  function automatic logic [11:0] pick_mv(input logic [1:0] target);
    logic [11:0] mv;
    mv = 12'($urandom);
    case (target)
      KEY_BOTH: if (both_min <= both_max) mv = 12'($urandom_range(both_max, both_min));
      KEY_TWO:  if (key2_min <= key2_max) mv = 12'($urandom_range(key2_max, key2_min));
      KEY_ONE:  if (key1_min <= key1_max) mv = 12'($urandom_range(key1_max, key1_min));
      default: begin
        for (int t = 0; t < 8 && classify_mv(mv) != KEY_NONE; t++) mv = 12'($urandom);
      end
    endcase
    return mv;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall at random according to the idling pattern
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    case (idle_mode)
      2:       m_axis_tready <= $urandom_range(0, 99) >= 47;
      3:       m_axis_tready <= $urandom_range(0, 99) >= 33;
      default: m_axis_tready <= 1'b1;
    endcase
  end

  // Compare each event transaction with the oldest expectation
  always @(posedge clk_i) begin : event_check
    key_event_t got;
    key_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, key: m_axis_tdata[1:0],
              raw: m_axis_tdata[13:2], mv: m_axis_tdata[25:14]};
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: expected no event, got kind %0d key %0d raw %03h mv %03h",
                 $time, got.kind, got.key, got.raw, got.mv);
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.key !== want.key ||
            got.raw !== want.raw || got.mv !== want.mv) begin
          mismatches++;
          $display("%0t: expected kind %0d key %0d raw %03h mv %03h, got kind %0d key %0d raw %03h mv %03h",
                   $time, want.kind, want.key, want.raw, want.mv,
                   got.kind, got.key, got.raw, got.mv);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table: reset windows first, then the directed register setting
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [25] = '{
    // setup now           raw      mv    err typed has kind           key
    '{1'b0, 32'd0,         12'h000, 12'd0,    1'b0, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd100,       12'hFFF, 12'd4095, 1'b0, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF,  1'b1, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b1, 32'd1000,      12'h123, 12'd1200, 1'b0, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd1003,      12'hAAA, 12'd1200, 1'b0, 1'b1, 1'b1, EV_DOWN,       KEY_ONE},
    '{1'b0, 32'd1004,      12'h555, 12'd0,    1'b1, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd1010,      12'h000, 12'd0,    1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    // release exactly 10 ms after the press stays quiet
    '{1'b0, 32'd1013,      12'h001, 12'd0,    1'b0, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd1100,      12'h002, 12'd2200, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd1103,      12'h003, 12'd2200, 1'b0, 1'b1, 1'b1, EV_DOWN,       KEY_TWO},
    '{1'b0, 32'd1110,      12'h004, 12'd4095, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd1114,      12'h005, 12'd4095, 1'b0, 1'b1, 1'b1, EV_SHORT,      KEY_TWO},
    // overlap of both and key two: both wins
    '{1'b0, 32'd2000,      12'h006, 12'd3050, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd2003,      12'h007, 12'd3050, 1'b0, 1'b1, 1'b1, EV_DOWN,       KEY_BOTH},
    '{1'b0, 32'd2803,      12'h008, 12'd3050, 1'b0, 1'b1, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd2804,      12'h009, 12'd3500, 1'b0, 1'b1, 1'b1, EV_LONG_START, KEY_BOTH},
    '{1'b0, 32'd2900,      12'h00A, 12'd3000, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd2950,      12'h00B, 12'd1000, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd3000,      12'h00C, 12'd999,  1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'd3003,      12'h00D, 12'd999,  1'b0, 1'b1, 1'b1, EV_LONG_END,   KEY_BOTH},
    // press across the timestamp wrap
    '{1'b0, 32'hFFFF_FFF0, 12'h00E, 12'd1500, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'hFFFF_FFFF, 12'h00F, 12'd1500, 1'b0, 1'b1, 1'b1, EV_DOWN,       KEY_ONE},
    '{1'b0, 32'h0000_0320, 12'h010, 12'd1400, 1'b0, 1'b1, 1'b1, EV_LONG_START, KEY_ONE},
    '{1'b0, 32'h0000_0400, 12'h011, 12'd1501, 1'b0, 1'b0, 1'b0, EV_DOWN,       KEY_NONE},
    '{1'b0, 32'h0000_0403, 12'h012, 12'd1501, 1'b0, 1'b1, 1'b1, EV_LONG_END,   KEY_ONE}
  };

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sample_t     s;
    key_event_t  ev;
    bit          has;
    logic [31:0] now_ms;
    logic [1:0]  target;
    int          run_left;
    int          r;
    int          lo;
    reset_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setup) begin
        wait_idle();
        set_plan(3000, 3500, 2000, 3100, 1000, 1500, 2, 800);
        write_cfg_plan();
      end
      s = '{now: dir_rows[i].now, raw: dir_rows[i].raw, mv: dir_rows[i].mv,
            err: dir_rows[i].err};
      send_sample(s, has, ev);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].t_has)
          pending_events.push_back('{kind: dir_rows[i].t_kind, key: dir_rows[i].t_key,
                                     raw: s.raw, mv: s.mv});
      end else if (has) begin
        pending_events.push_back(ev);
      end
    end

    // Random scan streams, one register setting and idling pattern per phase
    now_ms = 32'h0000_1000;
    run_left = 0;
    target = KEY_NONE;
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: set_plan(3000, 3500, 2000, 2500, 1000, 1500, 25, 800);
        1: set_plan(3400, 4095, 2200, 3000, 0, 1900, 0, 0);
        2: set_plan(3000, 3500, 2000, 2500, 1000, 1500, 65535, 65535);
        3: set_plan(0, 4095, 4095, 0, 4095, 0, 3, 50);
        4: set_plan(4095, 0, 1, 0, 2048, 2047, 5, 20);
        5: set_plan(2048, 2048, 4095, 4095, 0, 0, 1, 10);
        6: begin
          lo = $urandom_range(0, 4095);
          cfg_plan[REG_BOTH_MIN] = 16'(lo);
          cfg_plan[REG_BOTH_MAX] = 16'(rand_hi(lo, 600));
          lo = $urandom_range(0, 4095);
          cfg_plan[REG_KEY2_MIN] = 16'(lo);
          cfg_plan[REG_KEY2_MAX] = 16'(rand_hi(lo, 600));
          lo = $urandom_range(0, 4095);
          cfg_plan[REG_KEY1_MIN] = 16'(lo);
          cfg_plan[REG_KEY1_MAX] = 16'(rand_hi(lo, 600));
          cfg_plan[REG_DEBOUNCE] = 16'($urandom_range(0, 40));
          cfg_plan[REG_LONG] = 16'($urandom_range(0, 300));
        end
        default: begin
          lo = $urandom_range(0, 3000);
          cfg_plan[REG_BOTH_MIN] = 16'(lo);
          cfg_plan[REG_BOTH_MAX] = 16'(rand_hi(lo, 1500));
          lo = $urandom_range(0, 3000);
          cfg_plan[REG_KEY2_MIN] = 16'(lo);
          cfg_plan[REG_KEY2_MAX] = 16'(rand_hi(lo, 1500));
          lo = $urandom_range(0, 3000);
          cfg_plan[REG_KEY1_MIN] = 16'(lo);
          cfg_plan[REG_KEY1_MAX] = 16'(rand_hi(lo, 1500));
          cfg_plan[REG_DEBOUNCE] = 16'($urandom_range(0, 10));
          cfg_plan[REG_LONG] = 16'($urandom_range(0, 2000));
        end
      endcase
      write_cfg_plan();
      idle_mode = p % 4;

      for (int n = 0; n < 244; n++) begin
        // Hold one key for a run of samples, then pick another
        if (run_left == 0) begin
          target = 2'($urandom_range(0, 3));
          run_left = $urandom_range(1, 40);
        end
        run_left--;
        // Advance time on scales of the debounce and long-press thresholds
        r = $urandom_range(0, 99);
        if (r < 30)      now_ms = now_ms + $urandom_range(0, 3);
        else if (r < 70) now_ms = now_ms + $urandom_range(0, debounce_ms / 4 + 2);
        else if (r < 90) now_ms = now_ms + $urandom_range(0, long_press_ms / 8 + 2);
        else if (r < 97) now_ms = now_ms + $urandom_range(0, int'(debounce_ms)
                                                          + int'(long_press_ms) + 20);
        else             now_ms = $urandom;
        s.now = now_ms;
        s.raw = 12'($urandom);
        r = $urandom_range(0, 99);
        s.err = (r < 5);
        s.mv = (r < 12) ? 12'($urandom) : pick_mv(target);
        send_sample(s, has, ev);
        if (has) pending_events.push_back(ev);
      end
    end

    idle_mode = 0;
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/akdl_pkg.sv
rtl/adc_ladder_key_debounce_longpress.sv
tb/tb_top.sv
